@@ rtl/sto_pkg.sv @@
package sto_pkg;

  // Configuration port geometry.
  localparam int APB_ADDR_WIDTH = 4;
  localparam int APB_DATA_WIDTH = 32;

  // Each wide multiplier splits its second operand into this many chunks; MUL_LAT
  // is the depth of its register pipeline.
  localparam int MUL_CHUNKS = 4;
  localparam int MUL_LAT    = 3;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    RegCenterX = 2'd0,
    RegCenterY = 2'd1,
    RegCenterZ = 2'd2,
    RegRadius  = 2'd3
  } sto_reg_e;

endpackage

@@ rtl/sto_if.sv @@
interface sto_tri_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] first_z;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;
  logic signed [COORD_WIDTH-1:0] second_z;
  logic signed [COORD_WIDTH-1:0] third_x;
  logic signed [COORD_WIDTH-1:0] third_y;
  logic signed [COORD_WIDTH-1:0] third_z;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z,
           third_x, third_y, third_z,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
           third_x, third_y, third_z,
    output ready
  );
endinterface

interface sto_res_if;
  logic valid;
  logic ready;
  logic overlaps;

  modport source (output valid, overlaps, input ready);
  modport sink (input valid, overlaps, output ready);
endinterface

@@ rtl/sto_mul.sv @@
// Signed multiplier in three register stages: partial products of the first
// operand with each chunk of the second, then two pairwise sums, then the total.
module sto_mul #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int NC   = sto_pkg::MUL_CHUNKS;
  localparam int CB   = (BW + NC - 1) / NC;
  localparam int BPW  = NC * CB;
  localparam int PPW  = AW + CB + 1;
  localparam int SUMW = AW + BPW + 1;

  logic signed [BPW-1:0]    b_ext;
  logic signed [CB:0]       chunk [NC];
  logic signed [PPW-1:0]    pp_q [NC];
  logic signed [SUMW-1:0]   lo_q;
  logic signed [SUMW-1:0]   hi_q;
  logic signed [SUMW-1:0]   full;
  logic signed [AW+BW-1:0]  p_q;

  assign b_ext = BPW'(b_i);

  // Lower chunks are unsigned digits; the top chunk carries the sign.
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      if (k == NC - 1) begin
        chunk[k] = {b_ext[BPW-1], b_ext[k*CB +: CB]};
      end else begin
        chunk[k] = {1'b0, b_ext[k*CB +: CB]};
      end
    end
  end

  assign full = lo_q + (hi_q <<< (2 * CB));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NC; k++) begin
        pp_q[k] <= PPW'(a_i) * PPW'(chunk[k]);
      end
      lo_q <= SUMW'(pp_q[0]) + (SUMW'(pp_q[1]) <<< CB);
      hi_q <= SUMW'(pp_q[2]) + (SUMW'(pp_q[3]) <<< CB);
      p_q  <= full[AW+BW-1:0];
    end
  end

  assign p_o = p_q;

endmodule

@@ rtl/sphere_triangle_overlap.sv @@
// Sphere / triangle overlap test.
//
// Software writes the sphere center and radius over the APB-style port while
// the block is idle: center x, y, z at byte addresses 0x0, 0x4, 0x8 and the
// radius at 0xC. Reads return the stored values; pready is always high.
// Triangles arrive as words on tri_i (three vertices, valid/ready), and every
// triangle yields exactly one word on res_o whose overlaps bit is 1 when the
// sphere touches or intersects the triangle.
//
// The datapath is a 16-stage pipeline built around three rounds of
// multipliers (dot and cross products, then the degree-three and degree-four
// terms, then the degree-six terms), with adder and compare stages between
// them. One triangle is accepted every cycle while the output buffer has room.
//
// A two-word output buffer sits after the last stage. While it has room the
// pipeline advances and tri_i.ready is high, so new triangles keep entering
// while a finished result waits. When the receiver stalls long enough to fill
// the buffer, the whole pipeline freezes in place until a word is taken.
// Reset clears the configuration registers, all valid bits and the output buffer pointers.
module sphere_triangle_overlap #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  sto_tri_if.sink                             tri_i,
  sto_res_if.source                           res_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sto_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [sto_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [sto_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                pready
);

  localparam int ML   = sto_pkg::MUL_LAT;
  localparam int NSTG = 7 + 3 * ML;
  localparam int LAST = NSTG - 1;

  // Exact widths of every intermediate.
  localparam int AW   = COORD_WIDTH + 1;   // translated vertex
  localparam int EW   = COORD_WIDTH + 2;   // edge vector
  localparam int RW   = COORD_WIDTH;       // radius as a signed value
  localparam int RRW  = 2 * RW;            // radius squared
  localparam int CPW  = 2 * EW;            // cross product term
  localparam int VW   = CPW + 1;           // plane normal
  localparam int SPW  = 2 * AW;            // vertex dot term
  localparam int SW   = SPW + 2;           // vertex dot product
  localparam int EPW  = 2 * EW;            // edge dot term
  localparam int EEW  = EPW + 2;           // squared edge length
  localparam int DDW  = SW + 1;            // projection numerator on an edge
  localparam int DPW  = AW + VW;
  localparam int DW   = DPW + 2;           // plane distance numerator
  localparam int VPW  = 2 * VW;
  localparam int EVW  = VPW + 2;           // squared normal length
  localparam int PEW  = AW + EEW;          // vertex times squared edge length
  localparam int QW   = PEW + 1;           // closest point on an edge line
  localparam int QOW  = PEW + 2;           // closest point to opposite vertex
  localparam int E2W  = 2 * EEW;
  localparam int DSW  = 2 * DW;
  localparam int REW  = RRW + EVW;
  localparam int QPW  = 2 * QW;
  localparam int QSW  = QPW + 2;
  localparam int QOPW = QW + QOW;
  localparam int QOSW = QOPW + 2;
  localparam int RE2W = RRW + E2W;
  localparam int CMPW = 6 * COORD_WIDTH + 20;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] center_q [3];
  logic [COORD_WIDTH-2:0]        rad_q;
  logic signed [RW-1:0]          rad_s;
  sto_pkg::sto_reg_e             reg_sel;
  logic                          cfg_wr;

  assign reg_sel = sto_pkg::sto_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign rad_s   = signed'({1'b0, rad_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        center_q[i] <= '0;
      end
      rad_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        sto_pkg::RegCenterX: center_q[0] <= pwdata[COORD_WIDTH-1:0];
        sto_pkg::RegCenterY: center_q[1] <= pwdata[COORD_WIDTH-1:0];
        sto_pkg::RegCenterZ: center_q[2] <= pwdata[COORD_WIDTH-1:0];
        sto_pkg::RegRadius:  rad_q       <= pwdata[COORD_WIDTH-2:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      sto_pkg::RegCenterX: prdata = sto_pkg::APB_DATA_WIDTH'(center_q[0]);
      sto_pkg::RegCenterY: prdata = sto_pkg::APB_DATA_WIDTH'(center_q[1]);
      sto_pkg::RegCenterZ: prdata = sto_pkg::APB_DATA_WIDTH'(center_q[2]);
      sto_pkg::RegRadius:  prdata = sto_pkg::APB_DATA_WIDTH'(rad_q);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: every stage advances together while the output buffer
  // has room.
  // ---------------------------------------------------------------------------
  logic            en;
  logic [NSTG-1:0] vld_q;
  logic [1:0]      cnt_q;
  logic            wr_q;
  logic            rd_q;
  logic            res_q [2];
  logic            push;
  logic            pop;
  logic            ov15_q;

  assign en          = (cnt_q != 2'd2);
  assign tri_i.ready = en;
  assign push        = en && vld_q[LAST];
  assign pop         = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[NSTG-2:0], tri_i.valid};
      end
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push && pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q[wr_q] <= ov15_q;
    end
  end

  assign res_o.valid    = (cnt_q != 2'd0);
  assign res_o.overlaps = res_q[rd_q];

  // ---------------------------------------------------------------------------
  // Stages 0 and 1: move the vertices so the sphere center is the origin, then
  // form the edge vectors. Edge k runs from vertex k to vertex k+1.
  // ---------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] in_c [3][3];
  logic signed [AW-1:0] vtx0_q [3][3];
  logic signed [AW-1:0] vtx1_q [3][3];
  logic signed [EW-1:0] edge1_q [3][3];

  assign in_c[0][0] = tri_i.first_x;
  assign in_c[0][1] = tri_i.first_y;
  assign in_c[0][2] = tri_i.first_z;
  assign in_c[1][0] = tri_i.second_x;
  assign in_c[1][1] = tri_i.second_y;
  assign in_c[1][2] = tri_i.second_z;
  assign in_c[2][0] = tri_i.third_x;
  assign in_c[2][1] = tri_i.third_y;
  assign in_c[2][2] = tri_i.third_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        for (int ax = 0; ax < 3; ax++) begin
          vtx0_q[v][ax] <= AW'(in_c[v][ax]) - AW'(center_q[ax]);
        end
      end
      vtx1_q <= vtx0_q;
    end
  end

  // ---------------------------------------------------------------------------
  // First multiplier round (stages 2 to 4) and stages 5 and 6.
  // ---------------------------------------------------------------------------
  logic signed [CPW-1:0] cp_pos [3];
  logic signed [CPW-1:0] cp_neg [3];
  logic signed [SPW-1:0] sp [3][3];
  logic signed [SPW-1:0] xp [3][3];
  logic signed [EPW-1:0] ep [3][3];
  logic signed [RRW-1:0] rr_p;

  logic signed [AW-1:0]  vtx_dl_q [ML][3][3];
  logic signed [EW-1:0]  edge_dl_q [ML][3][3];

  logic signed [AW-1:0]  vtx5_q [3][3];
  logic signed [EW-1:0]  edge5_q [3][3];
  logic signed [VW-1:0]  v5_q [3];
  logic signed [SW-1:0]  s5_q [3];
  logic signed [SW-1:0]  x5_q [3];
  logic signed [EEW-1:0] ee5_q [3];
  logic signed [RRW-1:0] rr5_q;

  logic signed [AW-1:0]  vtx6_q [3][3];
  logic signed [EW-1:0]  edge6_q [3][3];
  logic signed [VW-1:0]  v6_q [3];
  logic signed [EEW-1:0] ee6_q [3];
  logic signed [DDW-1:0] dd6_q [3];
  logic [2:0]            vf6_q;
  logic signed [RRW-1:0] rr6_q;

  sto_mul #(.AW(RW), .BW(RW)) u_rr (
    .clk_i, .en_i(en), .a_i(rad_s), .b_i(rad_s), .p_o(rr_p)
  );

  for (genvar k = 0; k < 3; k++) begin : g_vtx
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int ax = 0; ax < 3; ax++) begin
          edge1_q[k][ax] <= EW'(vtx0_q[K1][ax]) - EW'(vtx0_q[k][ax]);
        end
        s5_q[k]  <= SW'(sp[k][0]) + SW'(sp[k][1]) + SW'(sp[k][2]);
        x5_q[k]  <= SW'(xp[k][0]) + SW'(xp[k][1]) + SW'(xp[k][2]);
        ee5_q[k] <= EEW'(ep[k][0]) + EEW'(ep[k][1]) + EEW'(ep[k][2]);
        dd6_q[k] <= DDW'(x5_q[k]) - DDW'(s5_q[k]);
        // Vertex k separates when it lies outside the sphere and both
        // neighbors lie beyond it as seen from the center.
        vf6_q[k] <= (s5_q[k] > SW'(rr5_q)) && (x5_q[k] > s5_q[k]) &&
                    (x5_q[K2] > s5_q[k]);
      end
    end

    for (genvar ax = 0; ax < 3; ax++) begin : g_ax
      sto_mul #(.AW(AW), .BW(AW)) u_sp (
        .clk_i, .en_i(en), .a_i(vtx1_q[k][ax]), .b_i(vtx1_q[k][ax]), .p_o(sp[k][ax])
      );
      sto_mul #(.AW(AW), .BW(AW)) u_xp (
        .clk_i, .en_i(en), .a_i(vtx1_q[k][ax]), .b_i(vtx1_q[K1][ax]), .p_o(xp[k][ax])
      );
      sto_mul #(.AW(EW), .BW(EW)) u_ep (
        .clk_i, .en_i(en), .a_i(edge1_q[k][ax]), .b_i(edge1_q[k][ax]), .p_o(ep[k][ax])
      );
    end
  end

  // Plane normal: (a - c) x (b - a), which is the triangle normal up to sign.
  for (genvar ax = 0; ax < 3; ax++) begin : g_cross
    localparam int A1 = (ax + 1) % 3;
    localparam int A2 = (ax + 2) % 3;

    sto_mul #(.AW(EW), .BW(EW)) u_cp_pos (
      .clk_i, .en_i(en), .a_i(edge1_q[2][A1]), .b_i(edge1_q[0][A2]), .p_o(cp_pos[ax])
    );
    sto_mul #(.AW(EW), .BW(EW)) u_cp_neg (
      .clk_i, .en_i(en), .a_i(edge1_q[2][A2]), .b_i(edge1_q[0][A1]), .p_o(cp_neg[ax])
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        v5_q[ax] <= VW'(cp_pos[ax]) - VW'(cp_neg[ax]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vtx_dl_q[0]  <= vtx1_q;
      edge_dl_q[0] <= edge1_q;
      for (int i = 1; i < ML; i++) begin
        vtx_dl_q[i]  <= vtx_dl_q[i-1];
        edge_dl_q[i] <= edge_dl_q[i-1];
      end
      vtx5_q  <= vtx_dl_q[ML-1];
      edge5_q <= edge_dl_q[ML-1];
      rr5_q   <= rr_p;
      vtx6_q  <= vtx5_q;
      edge6_q <= edge5_q;
      v6_q    <= v5_q;
      ee6_q   <= ee5_q;
      rr6_q   <= rr5_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Second multiplier round (stages 7 to 9) and stage 10. For edge k the
  // closest point on its line, scaled by the squared edge length, is
  // q = p*ee - edge*dd, and qo = o*ee - q points from it to the opposite vertex.
  // ---------------------------------------------------------------------------
  logic signed [DPW-1:0] dp [3];
  logic signed [VPW-1:0] vp [3];
  logic signed [PEW-1:0] pee [3][3];
  logic signed [PEW-1:0] edd [3][3];
  logic signed [PEW-1:0] oee [3][3];
  logic signed [E2W-1:0] ee2p [3];

  logic signed [RRW-1:0] rr_dl_q [ML];
  logic [2:0]            vf_dl_q [ML];

  logic signed [DW-1:0]  d10_q;
  logic signed [EVW-1:0] e10_q;
  logic signed [QW-1:0]  q10_q [3][3];
  logic signed [QOW-1:0] qo10_q [3][3];
  logic signed [E2W-1:0] ee2_10_q [3];
  logic signed [RRW-1:0] rr10_q;
  logic [2:0]            vf10_q;

  for (genvar ax = 0; ax < 3; ax++) begin : g_plane
    sto_mul #(.AW(AW), .BW(VW)) u_dp (
      .clk_i, .en_i(en), .a_i(vtx6_q[0][ax]), .b_i(v6_q[ax]), .p_o(dp[ax])
    );
    sto_mul #(.AW(VW), .BW(VW)) u_vp (
      .clk_i, .en_i(en), .a_i(v6_q[ax]), .b_i(v6_q[ax]), .p_o(vp[ax])
    );
  end

  for (genvar k = 0; k < 3; k++) begin : g_edge
    localparam int K2 = (k + 2) % 3;

    sto_mul #(.AW(EEW), .BW(EEW)) u_ee2 (
      .clk_i, .en_i(en), .a_i(ee6_q[k]), .b_i(ee6_q[k]), .p_o(ee2p[k])
    );

    for (genvar ax = 0; ax < 3; ax++) begin : g_ax
      sto_mul #(.AW(AW), .BW(EEW)) u_pee (
        .clk_i, .en_i(en), .a_i(vtx6_q[k][ax]), .b_i(ee6_q[k]), .p_o(pee[k][ax])
      );
      sto_mul #(.AW(EW), .BW(DDW)) u_edd (
        .clk_i, .en_i(en), .a_i(edge6_q[k][ax]), .b_i(dd6_q[k]), .p_o(edd[k][ax])
      );
      sto_mul #(.AW(AW), .BW(EEW)) u_oee (
        .clk_i, .en_i(en), .a_i(vtx6_q[K2][ax]), .b_i(ee6_q[k]), .p_o(oee[k][ax])
      );

      always_ff @(posedge clk_i) begin
        if (en) begin
          q10_q[k][ax]  <= QW'(pee[k][ax]) - QW'(edd[k][ax]);
          qo10_q[k][ax] <= QOW'(oee[k][ax]) - QOW'(pee[k][ax]) + QOW'(edd[k][ax]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rr_dl_q[0] <= rr6_q;
      vf_dl_q[0] <= vf6_q;
      for (int i = 1; i < ML; i++) begin
        rr_dl_q[i] <= rr_dl_q[i-1];
        vf_dl_q[i] <= vf_dl_q[i-1];
      end
      d10_q    <= DW'(dp[0]) + DW'(dp[1]) + DW'(dp[2]);
      e10_q    <= EVW'(vp[0]) + EVW'(vp[1]) + EVW'(vp[2]);
      ee2_10_q <= ee2p;
      rr10_q   <= rr_dl_q[ML-1];
      vf10_q   <= vf_dl_q[ML-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Third multiplier round (stages 11 to 13), sums in stage 14 and the final
  // compares in stage 15. Every test separates only on a strict inequality.
  // ---------------------------------------------------------------------------
  logic signed [DSW-1:0]  dsq;
  logic signed [REW-1:0]  rre;
  logic signed [QPW-1:0]  qqp [3][3];
  logic signed [QOPW-1:0] qop [3][3];
  logic signed [RE2W-1:0] rree [3];
  logic [2:0]             vf_dl2_q [ML];

  logic signed [DSW-1:0]  dsq14_q;
  logic signed [REW-1:0]  rre14_q;
  logic signed [QSW-1:0]  qq14_q [3];
  logic signed [QOSW-1:0] qo14_q [3];
  logic signed [RE2W-1:0] rree14_q [3];
  logic [2:0]             vf14_q;

  logic                   plane_sep;
  logic [2:0]             edge_sep;

  sto_mul #(.AW(DW), .BW(DW)) u_dsq (
    .clk_i, .en_i(en), .a_i(d10_q), .b_i(d10_q), .p_o(dsq)
  );
  sto_mul #(.AW(RRW), .BW(EVW)) u_rre (
    .clk_i, .en_i(en), .a_i(rr10_q), .b_i(e10_q), .p_o(rre)
  );

  for (genvar k = 0; k < 3; k++) begin : g_edge3
    sto_mul #(.AW(RRW), .BW(E2W)) u_rree (
      .clk_i, .en_i(en), .a_i(rr10_q), .b_i(ee2_10_q[k]), .p_o(rree[k])
    );

    for (genvar ax = 0; ax < 3; ax++) begin : g_ax
      sto_mul #(.AW(QW), .BW(QW)) u_qq (
        .clk_i, .en_i(en), .a_i(q10_q[k][ax]), .b_i(q10_q[k][ax]), .p_o(qqp[k][ax])
      );
      sto_mul #(.AW(QW), .BW(QOW)) u_qo (
        .clk_i, .en_i(en), .a_i(q10_q[k][ax]), .b_i(qo10_q[k][ax]), .p_o(qop[k][ax])
      );
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        qq14_q[k]   <= QSW'(qqp[k][0]) + QSW'(qqp[k][1]) + QSW'(qqp[k][2]);
        qo14_q[k]   <= QOSW'(qop[k][0]) + QOSW'(qop[k][1]) + QOSW'(qop[k][2]);
        rree14_q[k] <= rree[k];
      end
    end

    // The edge separates when the sphere misses the edge line and the
    // opposite vertex lies on the far side of it.
    assign edge_sep[k] = (CMPW'(qq14_q[k]) > CMPW'(rree14_q[k])) &&
                         (qo14_q[k] > QOSW'(0));
  end

  assign plane_sep = CMPW'(dsq14_q) > CMPW'(rre14_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      vf_dl2_q[0] <= vf10_q;
      for (int i = 1; i < ML; i++) begin
        vf_dl2_q[i] <= vf_dl2_q[i-1];
      end
      dsq14_q <= dsq;
      rre14_q <= rre;
      vf14_q  <= vf_dl2_q[ML-1];
      ov15_q  <= !(plane_sep || (|vf14_q) || (|edge_sep));
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tri_i.valid && tri_i.ready) |=> vld_q[0])
    else $error("accepted triangle did not enter the pipeline");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while the output buffer was full");

  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAST] && (cnt_q == 2'd2)) |=> vld_q[LAST])
    else $error("finished result dropped while the output buffer was full");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer overflow");

endmodule

@@ bench/sto_overlap_checker.sv @@
`timescale 1ns / 100ps

module sto_overlap_checker #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sto_tri_if.sink                       tri_mon,
  sto_res_if.sink                       res_mon,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic signed [COORD_WIDTH-1:0] center_z,
  input  logic [COORD_WIDTH-2:0]        sphere_radius,
  output int                            fail_count,
  output int                            pending_count,
  output int                            result_count,
  output int                            overlap_count
);

  // Products reach degree six in 17-bit differences, so 128 bits is ample.
  typedef logic signed [127:0] acc_t;
  typedef acc_t vec_t [3];

  bit overlap_q [$];

  function automatic acc_t dot3(vec_t a, vec_t b);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic bit edge_separates(vec_t p, vec_t r, vec_t o, acc_t pp, acc_t pr,
                                        acc_t rr);
    vec_t e, q, qo;
    acc_t dd, ee;
    dd = pr - pp;
    for (int i = 0; i < 3; i++) e[i] = r[i] - p[i];
    ee = dot3(e, e);
    for (int i = 0; i < 3; i++) begin
      q[i]  = p[i] * ee - e[i] * dd;
      qo[i] = o[i] * ee - q[i];
    end
    return (dot3(q, q) > rr * ee * ee) && (dot3(q, qo) > 0);
  endfunction

  function automatic bit predict_overlap(acc_t ax, acc_t ay, acc_t az, acc_t bx, acc_t by,
                                         acc_t bz, acc_t cx, acc_t cy, acc_t cz);
    vec_t a, b, c, u, w, n;
    acc_t rr, aa, ab, ac, bb, bc, cc, d;
    bit sep;
    a = '{ax - center_x, ay - center_y, az - center_z};
    b = '{bx - center_x, by - center_y, bz - center_z};
    c = '{cx - center_x, cy - center_y, cz - center_z};
    rr = acc_t'(sphere_radius) * acc_t'(sphere_radius);
    for (int i = 0; i < 3; i++) begin
      u[i] = b[i] - a[i];
      w[i] = c[i] - a[i];
    end
    n[0] = u[1] * w[2] - u[2] * w[1];
    n[1] = u[2] * w[0] - u[0] * w[2];
    n[2] = u[0] * w[1] - u[1] * w[0];
    d = dot3(a, n);
    sep = d * d > rr * dot3(n, n);
    aa = dot3(a, a); ab = dot3(a, b); ac = dot3(a, c);
    bb = dot3(b, b); bc = dot3(b, c); cc = dot3(c, c);
    sep |= (aa > rr) && (ab > aa) && (ac > aa);
    sep |= (bb > rr) && (ab > bb) && (bc > bb);
    sep |= (cc > rr) && (ac > cc) && (bc > cc);
    sep |= edge_separates(a, b, c, aa, ab, rr);
    sep |= edge_separates(b, c, a, bb, bc, rr);
    sep |= edge_separates(c, a, b, cc, ac, rr);
    return !sep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count    <= 0;
      pending_count <= 0;
      result_count  <= 0;
      overlap_count <= 0;
    end else begin
      if (tri_mon.valid && tri_mon.ready) begin
        overlap_q.push_back(predict_overlap(tri_mon.first_x, tri_mon.first_y,
          tri_mon.first_z, tri_mon.second_x, tri_mon.second_y, tri_mon.second_z,
          tri_mon.third_x, tri_mon.third_y, tri_mon.third_z));
      end
      if (res_mon.valid && res_mon.ready) begin
        result_count <= result_count + 1;
        if (res_mon.overlaps) overlap_count <= overlap_count + 1;
        if (overlap_q.size() == 0) begin
          $error("result word with no triangle waiting: overlaps=%0b", res_mon.overlaps);
          fail_count <= fail_count + 1;
        end else if (overlap_q.pop_front() !== res_mon.overlaps) begin
          $error("field overlaps: expected %0b, actual %0b", !res_mon.overlaps,
                 res_mon.overlaps);
          fail_count <= fail_count + 1;
        end
      end
      pending_count <= overlap_q.size();
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

// Top of the bench for the sphere/triangle overlap block. It writes the sphere
// through the APB-style port, streams triangle words in with random gaps, drains
// result words with random stalls, and leaves prediction to the checker.
module tb;

  localparam int CW       = 16;
  localparam int LATENCY  = 16;
  localparam int WATCHDOG = 5000;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [sto_pkg::APB_ADDR_WIDTH-1:0] paddr;
  logic [sto_pkg::APB_DATA_WIDTH-1:0] pwdata, prdata;
  logic pready;

  // Shadow of the sphere registers; the checker predicts from these.
  logic signed [CW-1:0] center_x, center_y, center_z;
  logic [CW-2:0]        sphere_radius;

  int fail_count, pending_count, result_count, overlap_count;
  int idle_cycles;
  bit long_stall;
  bit stim_done;

  sto_tri_if #(.COORD_WIDTH(CW)) tri_ch ();
  sto_res_if res_ch ();

  sphere_triangle_overlap #(.COORD_WIDTH(CW)) dut (
    .clk_i, .rst_ni, .tri_i(tri_ch), .res_o(res_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sto_overlap_checker #(.COORD_WIDTH(CW)) u_checker (
    .clk_i, .rst_ni, .tri_mon(tri_ch), .res_mon(res_ch),
    .center_x, .center_y, .center_z, .sphere_radius,
    .fail_count, .pending_count, .result_count, .overlap_count
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Two-phase register write: setup cycle, access cycle, then the bus goes idle.
  task automatic write_reg(sto_pkg::sto_reg_e idx,
                           logic [sto_pkg::APB_DATA_WIDTH-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      sto_pkg::RegCenterX: center_x <= value[CW-1:0];
      sto_pkg::RegCenterY: center_y <= value[CW-1:0];
      sto_pkg::RegCenterZ: center_z <= value[CW-1:0];
      default:             sphere_radius <= value[CW-2:0];
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_sphere(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
                            logic [CW-2:0] rad);
    write_reg(sto_pkg::RegCenterX, {{16{cx[CW-1]}}, cx});
    write_reg(sto_pkg::RegCenterY, {{16{cy[CW-1]}}, cy});
    write_reg(sto_pkg::RegCenterZ, {{16{cz[CW-1]}}, cz});
    write_reg(sto_pkg::RegRadius, {17'd0, rad});
  endtask

  // Block is idle only once every result has returned and the pipe has flushed.
  task automatic wait_drained();
    while (pending_count != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  // Leaves valid high on return; the caller drops it after its last word.
  task automatic send_triangle(logic [CW-1:0] v [9]);
    repeat ($urandom_range(0, 3)) begin
      tri_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    tri_ch.valid    <= 1'b1;
    tri_ch.first_x  <= v[0]; tri_ch.first_y  <= v[1]; tri_ch.first_z  <= v[2];
    tri_ch.second_x <= v[3]; tri_ch.second_y <= v[4]; tri_ch.second_z <= v[5];
    tri_ch.third_x  <= v[6]; tri_ch.third_y  <= v[7]; tri_ch.third_z  <= v[8];
    @(posedge clk_i);
    while (!tri_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random coordinate: mostly near the sphere so every test gets exercised,
  // sometimes anywhere in the full range.
  function automatic logic [CW-1:0] near(logic signed [CW-1:0] c, int spread);
    int v;
    if ($urandom_range(0, 7) == 0) return CW'($urandom);
    v = int'(c) + $signed($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[CW-1:0];
  endfunction

  task automatic random_triangles(int count);
    logic [CW-1:0] v [9];
    int spread;
    for (int n = 0; n < count; n++) begin
      spread = (sphere_radius == 0) ? 64 : 2 * sphere_radius + 8;
      if (spread > 32767) spread = 32767;
      for (int k = 0; k < 9; k++)
        v[k] = near(k % 3 == 0 ? center_x : k % 3 == 1 ? center_y : center_z, spread);
      case ($urandom_range(0, 9))
        0: for (int k = 0; k < 3; k++) v[6 + k] = v[k];  // zero-length edge
        1: for (int k = 0; k < 3; k++)                    // collinear vertices
             v[6 + k] = CW'(2 * v[3 + k] - v[k]);
        default: ;
      endcase
      send_triangle(v);
    end
    tri_ch.valid <= 1'b0;
  endtask

  task automatic directed_triangles();
    logic [CW-1:0] v [9];
    // Extremes of every field, all-max and all-min and mixed.
    v = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
          16'h7fff, 16'h8000, 16'h0000};
    send_triangle(v);
    v = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
          16'h8000, 16'h8000, 16'h7fff};
    send_triangle(v);
    v = '{default: 16'hffff};
    send_triangle(v);                                     // point triangle
    v = '{default: 16'h0000};
    send_triangle(v);
    // Touching: plane z=10 at radius 10 about the origin (radius set below).
    v = '{16'hff00, 16'hff00, 16'd10, 16'h0100, 16'hff00, 16'd10,
          16'd0, 16'h0100, 16'd10};
    send_triangle(v);
    v = '{16'hff00, 16'hff00, 16'd11, 16'h0100, 16'hff00, 16'd11,
          16'd0, 16'h0100, 16'd11};
    send_triangle(v);
    // Vertex touching, vertex just outside.
    v = '{16'd10, 16'd0, 16'd0, 16'd100, 16'd0, 16'd0, 16'd100, 16'd100, 16'd0};
    send_triangle(v);
    v = '{16'd11, 16'd0, 16'd0, 16'd100, 16'd0, 16'd0, 16'd100, 16'd100, 16'd0};
    send_triangle(v);
    // Edge touching, edge just outside.
    v = '{16'hff00, 16'd10, 16'd0, 16'h0100, 16'd10, 16'd0, 16'd0, 16'd100, 16'd0};
    send_triangle(v);
    v = '{16'hff00, 16'd11, 16'd0, 16'h0100, 16'd11, 16'd0, 16'd0, 16'd100, 16'd0};
    send_triangle(v);
    // Collinear and zero-length edges.
    v = '{16'd0, 16'd0, 16'd5, 16'd20, 16'd0, 16'd5, 16'd40, 16'd0, 16'd5};
    send_triangle(v);
    v = '{16'd30, 16'd30, 16'd30, 16'd30, 16'd30, 16'd30, 16'd60, 16'd0, 16'd0};
    send_triangle(v);
    tri_ch.valid <= 1'b0;
  endtask

  // Result side: a random wait before each word until the stimulus is done, and
  // one long hold-off when asked for.
  initial begin
    int wait_n;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (long_stall) begin
        res_ch.ready <= 1'b0;
        repeat (200) @(negedge clk_i);
        long_stall = 1'b0;
      end
      wait_n = stim_done ? 0 : $urandom_range(0, 3);
      if (wait_n > 0) begin
        res_ch.ready <= 1'b0;
        repeat (wait_n) @(negedge clk_i);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_ch.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Watchdog on cycles without any accepted word or register access.
  always @(posedge clk_i) begin
    if ((tri_ch.valid && tri_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("sphere_triangle_overlap test failed");
      $finish;
    end
  end

  initial begin
    idle_cycles = 0;
    stim_done = 1'b0;
    long_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    tri_ch.valid = 1'b0;
    {tri_ch.first_x, tri_ch.first_y, tri_ch.first_z} = '0;
    {tri_ch.second_x, tri_ch.second_y, tri_ch.second_z} = '0;
    {tri_ch.third_x, tri_ch.third_y, tri_ch.third_z} = '0;
    center_x = '0; center_y = '0; center_z = '0; sphere_radius = '0;
    rst_ni = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset values first: zero radius at the origin.
    directed_triangles();
    wait_drained();
    set_sphere(16'd0, 16'd0, 16'd0, 15'd10);
    directed_triangles();
    wait_drained();

    // Several spheres, including the extremes of center and radius.
    set_sphere(16'h7fff, 16'h8000, 16'h7fff, 15'h7fff);
    random_triangles(250);
    long_stall = 1'b1;                   // receiver holds off, pipeline fills
    random_triangles(150);
    wait_drained();                      // sender pauses until all returned
    set_sphere(16'h8000, 16'h7fff, 16'h8000, 15'd0);
    random_triangles(250);
    wait_drained();
    set_sphere(CW'($urandom), CW'($urandom), CW'($urandom), 15'($urandom_range(1, 200)));
    random_triangles(350);
    wait_drained();
    set_sphere(16'd0, 16'd0, 16'd0, 15'h7fff);
    random_triangles(300);
    wait_drained();
    set_sphere(CW'($urandom), CW'($urandom), CW'($urandom), 15'($urandom));
    random_triangles(276);

    stim_done = 1'b1;
    wait_drained();
    $display("Covered %0d triangles over seven sphere settings; %0d reported overlap.",
             result_count, overlap_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("sphere_triangle_overlap test passed");
    end else begin
      $display("sphere_triangle_overlap test failed");
    end
    $finish;
  end

endmodule
